### hdl/srwa_pkg.sv
// ---------------------------------------------------------------------------
// Scheduled running weight average package
// Shared widths, parameter defaults, command codes and register indexes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srwa_pkg;

  localparam int unsigned IDX_W           = 10;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned NUM_WEIGHTS_DEF = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 32;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_NEW  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STEP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 1'd1;

endpackage

`default_nettype wire

### hdl/scheduled_running_weight_average.sv
// ---------------------------------------------------------------------------
// Scheduled running weight average
// Store of averaged Q16.16 weights with a step schedule; updates move an
// entry toward a new weight by the difference divided by the averaged count.
//
//   Channel   Signals                                      Transfer
//   command   start, busy, cmd_i, entry_index_i, weight_i  start && !busy
//   result    done_o, avg_value_o, averaging_step_o,       done_o high
//             status_o
//   config    cfg_we_i, cfg_index_i, cfg_data_i            cfg_we_i high
//
// A load or an early read gives its result in the cycle after the transfer; a
// read, a plain weight or a step end at or before the start step first passes
// through the read or step state. A later step end or an averaging update runs
// the shared restoring divider, one quotient bit per cycle.
// Reset clears the counters and the schedule flag; the store is not cleared.
// The receiver takes every result in the cycle that it is shown.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scheduled_running_weight_average #(
  parameter int unsigned NUM_WEIGHTS = srwa_pkg::NUM_WEIGHTS_DEF,
  parameter int unsigned WEIGHT_BITS = srwa_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     cmd_i,
  input  wire logic [srwa_pkg::IDX_W-1:0]     entry_index_i,
  input  wire logic signed [WEIGHT_BITS-1:0]  weight_i,
  output logic                                done_o,
  output logic signed [WEIGHT_BITS-1:0]       avg_value_o,
  output logic                                averaging_step_o,
  output logic                                status_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [srwa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [srwa_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IdxRange = 2 ** srwa_pkg::IDX_W;
  localparam int unsigned Depth    = (NUM_WEIGHTS < IdxRange) ? NUM_WEIGHTS : IdxRange;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DivW     = (WEIGHT_BITS > srwa_pkg::CNT_W) ? WEIGHT_BITS
                                                                      : srwa_pkg::CNT_W;
  localparam int unsigned CntW     = srwa_pkg::CNT_W;
  localparam int unsigned CfgW     = srwa_pkg::CFG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  localparam logic [WEIGHT_BITS-1:0] SignBit = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [CntW-1:0]        CntMax  = '1;

  logic [1:0]             state_q, state_d;
  logic [1:0]             cmd_q;
  logic [AddrW-1:0]       idx_q;
  logic                   valid_q;
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [WEIGHT_BITS-1:0] avg_q, avg_d;
  logic                   neg_q, neg_d;
  logic [CntW-1:0]        step_cnt_q, step_cnt_d;
  logic [CntW-1:0]        avg_cnt_q, avg_cnt_d;
  logic                   flag_q, flag_d;
  logic [CfgW-1:0]        start_step_q;
  logic [CfgW-1:0]        period_q;
  logic [WEIGHT_BITS-1:0] res_value_q, res_value_d;
  logic                   status_q, status_d;
  logic                   done_q, done_d;

  logic                   accept;
  logic                   in_valid;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic [WEIGHT_BITS-1:0] mem_rdata;
  logic                   div_start;
  logic [DivW-1:0]        div_dividend;
  logic [CntW-1:0]        div_divisor;
  logic                   div_done;
  logic [DivW-1:0]        div_quot;
  logic [CntW-1:0]        div_rem;
  logic [WEIGHT_BITS-1:0] ab;
  logic [WEIGHT_BITS-1:0] wb;
  logic [WEIGHT_BITS-1:0] mag;
  logic [WEIGHT_BITS-1:0] quot_w;
  logic [CfgW-1:0]        period_eff;

  assign accept     = start && !busy;
  assign busy       = state_q != S_IDLE;
  assign in_valid   = 32'(entry_index_i) < 32'(NUM_WEIGHTS);
  assign ab         = mem_rdata ^ SignBit;
  assign wb         = weight_q ^ SignBit;
  assign mag        = (wb >= ab) ? (wb - ab) : (ab - wb);
  assign quot_w     = div_quot[WEIGHT_BITS-1:0];
  assign period_eff = (period_q == '0) ? CfgW'(1) : period_q;

  always_comb begin
    state_d      = state_q;
    avg_d        = avg_q;
    neg_d        = neg_q;
    step_cnt_d   = step_cnt_q;
    avg_cnt_d    = avg_cnt_q;
    flag_d       = flag_q;
    res_value_d  = res_value_q;
    status_d     = 1'b0;
    done_d       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = weight_i;
    div_start    = 1'b0;
    div_dividend = DivW'(step_cnt_q - CntW'(start_step_q));
    div_divisor  = CntW'(period_eff);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            srwa_pkg::CMD_LOAD: begin
              mem_we      = in_valid;
              mem_waddr   = entry_index_i[AddrW-1:0];
              mem_wdata   = weight_i;
              res_value_d = in_valid ? weight_i : '0;
              done_d      = 1'b1;
            end
            srwa_pkg::CMD_STEP: begin
              if (step_cnt_q != CntMax) begin
                step_cnt_d = step_cnt_q + CntW'(1);
              end
              state_d = S_STEP;
            end
            srwa_pkg::CMD_NEW: begin
              state_d = S_READ;
            end
            srwa_pkg::CMD_READ: begin
              if (avg_cnt_q == '0) begin
                res_value_d = '0;
                status_d    = 1'b1;
                done_d      = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        if (step_cnt_q > CntW'(start_step_q)) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          flag_d      = 1'b0;
          res_value_d = '0;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_READ: begin
        if (!valid_q) begin
          res_value_d = '0;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else if (cmd_q == srwa_pkg::CMD_NEW && flag_q) begin
          avg_d        = mem_rdata;
          neg_d        = wb < ab;
          div_dividend = DivW'(mag);
          div_divisor  = (avg_cnt_q == '0) ? CntW'(1) : avg_cnt_q;
          div_start    = 1'b1;
          state_d      = S_DIV;
        end else begin
          res_value_d = mem_rdata;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == srwa_pkg::CMD_STEP) begin
            flag_d      = div_rem == '0;
            res_value_d = '0;
            if (div_rem == '0 && avg_cnt_q != CntMax) begin
              avg_cnt_d = avg_cnt_q + CntW'(1);
            end
          end else begin
            mem_we      = 1'b1;
            mem_wdata   = neg_q ? (avg_q - quot_w) : (avg_q + quot_w);
            res_value_d = mem_wdata;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_cnt_q   <= '0;
      avg_cnt_q    <= '0;
      flag_q       <= 1'b0;
      start_step_q <= '0;
      period_q     <= CfgW'(1);
      status_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_cnt_q <= step_cnt_d;
      avg_cnt_q  <= avg_cnt_d;
      flag_q     <= flag_d;
      status_q   <= status_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          srwa_pkg::CFG_START_STEP:    start_step_q <= cfg_data_i;
          srwa_pkg::CFG_UPDATE_PERIOD: period_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      idx_q    <= entry_index_i[AddrW-1:0];
      valid_q  <= in_valid;
      weight_q <= weight_i;
    end
    avg_q       <= avg_d;
    neg_q       <= neg_d;
    res_value_q <= res_value_d;
  end

  srwa_ram #(
    .WIDTH(WEIGHT_BITS),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(entry_index_i[AddrW-1:0]),
    .rdata_o(mem_rdata)
  );

  srwa_div #(
    .DIVIDEND_W(DivW),
    .DIVISOR_W (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  assign done_o           = done_q;
  assign avg_value_o      = res_value_q;
  assign averaging_step_o = flag_q;
  assign status_o         = status_q;

  // A result is only shown once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while busy");

  // The averaged count only moves upward.
  assert property (@(posedge clk_i) disable iff (!rst_ni) avg_cnt_q >= $past(avg_cnt_q))
    else $error("averaged count decreased");

  // The divider is only launched from the step or read states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == S_STEP || state_q == S_READ))
    else $error("divider started from a wrong state");

  // An early read reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> avg_value_o == '0)
    else $error("flagged read with nonzero value");

endmodule

`default_nettype wire

### hdl/srwa_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/srwa_div.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, with a one-cycle done pulse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srwa_div #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output logic      [DIVISOR_W-1:0]  remainder_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W + 1);

  logic                  run_q;
  logic [CntW-1:0]       cnt_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] quot_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_q, quot_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DIVIDEND_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (run_q) begin
      rem_q  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quot_q <= {quot_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// Scheduled running weight average testbench
// Drives load, end-of-step, new-weight and read commands into the block
// under several schedule settings. A predictor of the store, counters and
// schedule computes the expected results, but typed rows of the directed
// table carry their own; a monitor compares every result with the oldest
// expectation. The directed table comes first, then random traffic in bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_ENTRIES = 1024;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DIR_ROWS    = 20;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic        status;
  } avg_result_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  idx;
    logic [31:0] w;
    logic        typed;
    avg_result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{srwa_pkg::CMD_LOAD, 10'h000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_LOAD, 10'h3FF, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_LOAD, 10'h155, 32'h0001_0000, 1'b1, '{32'h0001_0000, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_LOAD, 10'h2AA, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_READ, 10'h000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
    '{srwa_pkg::CMD_NEW,  10'h3FF, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_STEP, 10'h000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h000, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h3FF, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_READ, 10'h000, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_STEP, 10'h3FF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h155, 32'h0003_0000, 1'b1, '{32'h0002_0000, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h2AA, 32'hFFFF_FFFD, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h2AA, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_READ, 10'h155, 32'h1234_5678, 1'b1, '{32'h0002_0000, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_LOAD, 10'h0F0, 32'hA5A5_5A5A, 1'b1, '{32'hA5A5_5A5A, 1'b1, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h0F0, 32'h5A5A_A5A5, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_NEW,  10'h0F0, 32'h1234_5678, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_STEP, 10'h0F0, 32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
    '{srwa_pkg::CMD_READ, 10'h3FF, 32'h0000_0000, 1'b0, '{32'h0, 1'b0, 1'b0}}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [1:0]                     cmd_i = srwa_pkg::CMD_LOAD;
  logic [srwa_pkg::IDX_W-1:0]     entry_index_i = '0;
  logic signed [31:0]             weight_i = '0;
  logic                           done_o;
  logic signed [31:0]             avg_value_o;
  logic                           averaging_step_o;
  logic                           status_o;
  logic                           cfg_we_i = 1'b0;
  logic [srwa_pkg::CFG_IDX_W-1:0] cfg_index_i = srwa_pkg::CFG_START_STEP;
  logic [srwa_pkg::CFG_W-1:0]     cfg_data_i = '0;

  // Predictor state.
  logic [31:0] avg_mem [NUM_ENTRIES];
  bit          written [NUM_ENTRIES];
  int          written_list [$];
  logic [31:0] step_cnt;
  logic [15:0] phase_cnt;
  logic [31:0] avg_cnt;
  logic        avg_flag;
  logic [15:0] sched_start;
  logic [15:0] sched_period;

  avg_result_t pending_q [$];
  avg_result_t seen_want;
  int          mismatch_cnt = 0;
  int          cmd_count [4];
  int          avg_step_cnt;
  int          setting_cnt;
  int          burst_left;
  int unsigned cycle_cnt = 0;

  always #2 clk_i = ~clk_i;

  scheduled_running_weight_average dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .entry_index_i    (entry_index_i),
    .weight_i         (weight_i),
    .done_o           (done_o),
    .avg_value_o      (avg_value_o),
    .averaging_step_o (averaging_step_o),
    .status_o         (status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout with %0d results still expected.", pending_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("Unexpected result at %0t: value %h flag %b status %b", $realtime,
                   avg_value_o, averaging_step_o, status_o);
        end
      end else begin
        seen_want = pending_q.pop_front();
        if (avg_value_o !== seen_want.value || averaging_step_o !== seen_want.flag ||
            status_o !== seen_want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Mismatch at %0t: value %h/%h flag %b/%b status %b/%b (exp/act)",
                     $realtime, seen_want.value, avg_value_o, seen_want.flag,
                     averaging_step_o, seen_want.status, status_o);
          end
        end
      end
    end
  end

  function automatic logic [31:0] blend_toward(logic [31:0] cur, logic [31:0] w,
                                               logic [31:0] n);
    logic [31:0] d;
    logic [31:0] cb;
    logic [31:0] wb;
    logic [31:0] q;
    d  = (n == 0) ? 32'd1 : n;
    cb = cur ^ 32'h8000_0000;
    wb = w ^ 32'h8000_0000;
    if (wb >= cb) begin
      q = (wb - cb) / d;
      return cur + q;
    end
    q = (cb - wb) / d;
    return cur - q;
  endfunction

  task automatic apply_average_cmd(input logic [1:0] cmd, input logic [9:0] idx,
                                   input logic [31:0] w, output avg_result_t res);
    logic [31:0] per;
    logic [31:0] rem;
    res = '0;
    case (cmd)
      srwa_pkg::CMD_LOAD: begin
        avg_mem[idx] = w;
        res.value = w;
        if (!written[idx]) begin
          written[idx] = 1'b1;
          written_list = {written_list, int'(idx)};
        end
      end
      srwa_pkg::CMD_STEP: begin
        per = (sched_period == 0) ? 32'd1 : {16'd0, sched_period};
        if (step_cnt != '1) step_cnt++;
        if (step_cnt > {16'd0, sched_start}) begin
          rem       = (step_cnt - {16'd0, sched_start}) % per;
          phase_cnt = rem[15:0];
          avg_flag  = (rem == 0);
        end else begin
          phase_cnt = '0;
          avg_flag  = 1'b0;
        end
        if (avg_flag && avg_cnt != '1) avg_cnt++;
        if (avg_flag) avg_step_cnt++;
      end
      srwa_pkg::CMD_NEW: begin
        if (avg_flag) avg_mem[idx] = blend_toward(avg_mem[idx], w, avg_cnt);
        res.value = avg_mem[idx];
      end
      default: begin
        if (avg_cnt == 0) res.status = 1'b1;
        else res.value = avg_mem[idx];
      end
    endcase
    res.flag = avg_flag;
    cmd_count[cmd]++;
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [9:0] idx, input logic [31:0] w,
                       input logic typed, input avg_result_t typed_res);
    avg_result_t res;
    avg_result_t entry;
    @(negedge clk_i);
    start         <= 1'b1;
    cmd_i         <= cmd;
    entry_index_i <= idx;
    weight_i      <= w;
    while (busy) @(negedge clk_i);
    apply_average_cmd(cmd, idx, w, res);
    entry     = typed ? typed_res : res;
    pending_q = {pending_q, entry};
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic write_schedule(input logic [15:0] s, input logic [15:0] p);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= srwa_pkg::CFG_START_STEP;
    cfg_data_i  <= s;
    @(negedge clk_i);
    cfg_index_i <= srwa_pkg::CFG_UPDATE_PERIOD;
    cfg_data_i  <= p;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sched_start  = s;
    sched_period = p;
    setting_cnt++;
  endtask

  function automatic logic [31:0] pick_weight(logic [9:0] idx);
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return avg_mem[idx] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int n, input int step_weight);
    int          k;
    int          pick;
    logic [1:0]  cmd;
    logic [9:0]  idx;
    logic [31:0] w;
    for (k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 40));
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 15) cmd = srwa_pkg::CMD_LOAD;
      else if (pick < 15 + step_weight) cmd = srwa_pkg::CMD_STEP;
      else if (pick < 80) cmd = srwa_pkg::CMD_NEW;
      else cmd = srwa_pkg::CMD_READ;
      if (cmd == srwa_pkg::CMD_LOAD || cmd == srwa_pkg::CMD_STEP) begin
        idx = 10'($urandom_range(0, NUM_ENTRIES - 1));
      end else if ($urandom_range(0, 1) == 0 && written_list.size() > 16) begin
        idx = 10'(written_list[$urandom_range(0, 15)]);
      end else begin
        idx = 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
      end
      w = pick_weight(idx);
      issue(cmd, idx, w, 1'b0, '0);
    end
  endtask

  initial begin
    int r;
    step_cnt     = '0;
    phase_cnt    = '0;
    avg_cnt      = '0;
    avg_flag     = 1'b0;
    sched_start  = '0;
    sched_period = 16'd1;
    avg_step_cnt = 0;
    setting_cnt  = 0;
    burst_left   = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    foreach (written[i]) written[i] = 1'b0;
    foreach (avg_mem[i]) avg_mem[i] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_schedule(16'd0, 16'd1);
    for (r = 0; r < DIR_ROWS; r++) begin
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 5));
      issue(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].w, DIRECTED[r].typed,
            DIRECTED[r].want);
    end
    run_random(300, 25);

    write_schedule(16'hFFFF, 16'hFFFF);
    run_random(100, 30);
    write_schedule(step_cnt[15:0] + 16'd5, 16'd3);
    run_random(300, 30);
    write_schedule(16'd0, 16'd0);
    run_random(200, 25);
    write_schedule(step_cnt[15:0] + 16'd2, 16'd7);
    run_random(300, 35);
    write_schedule(16'd1, 16'hFFFF);
    run_random(100, 25);
    write_schedule(16'($urandom_range(0, 64)), 16'($urandom_range(1, 5)));
    run_random(200, 30);
    write_schedule(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    run_random(100, 25);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d transfers: %0d loads, %0d step ends, %0d new weights, %0d reads.",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("%0d averaging steps under %0d schedule settings, final phase %0d, %0d mismatches.",
             avg_step_cnt, setting_cnt, phase_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/srwa_pkg.sv
hdl/srwa_ram.sv
hdl/srwa_div.sv
hdl/scheduled_running_weight_average.sv
tb/tb_top.sv
